>>> rtl/core/gis_pkg.sv
// Shared types and constants for the segment locator.
// Holds the payload structs, action and status codes, controller states and
// the command and status bundles between controller and datapath.
package gis_pkg;

  localparam int VALUE_W = 42;
  localparam int SEG_W   = 11;
  localparam int OFF_W   = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEG_W-1:0] segment_number;
    logic [OFF_W-1:0] offset_in_segment;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_BEFORE,
    S_RESULT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic start;
    logic step;
    logic finish;
    logic emit;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic search_go;
    logic more;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/gis_stream_if.sv
// Valid/ready channel carrying one request or result per handshake.
// The payload type is set where the channel is instantiated.
interface gis_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/gis_ctrl.sv
// Controller state machine of the segment locator.
// Depends on gis_pkg for the state type and the command and status bundles.
module gis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  gis_pkg::stat_t stat,
  output gis_pkg::cmd_t  cmd
);
  import gis_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = stat.search_go ? S_SEARCH : S_RESULT;
      end
      S_SEARCH: begin
        if (!stat.more) state_next = S_BEFORE;
      end
      S_BEFORE: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.start  = stat.search_go;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
      end
      S_BEFORE: begin
        cmd.finish = 1'b1;
      end
      S_RESULT: begin
        cmd.emit = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/gis_datapath.sv
// Datapath of the segment locator: prefix-sum memory, table counters,
// binary-search bounds and the result register. Depends on gis_pkg.
module gis_datapath #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int SIZE_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  gis_pkg::cmd_t       cmd,
  output gis_pkg::stat_t      stat,
  input  gis_pkg::in_item_t   item_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gis_pkg::out_item_t  out_data
);
  import gis_pkg::*;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SNW   = (CNT_W + 1 > SEG_W) ? CNT_W + 1 : SEG_W;
  localparam logic [VALUE_W-1:0] SIZE_MAX = (SIZE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} :
                                            VALUE_W'((64'd1 << SIZE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_SEGMENTS);

  logic [VALUE_W-1:0] mem [MAX_SEGMENTS];

  action_t            act;
  logic [VALUE_W-1:0] val;
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] total;
  logic [CNT_W-1:0]   lo, hi, mid_q;
  logic [VALUE_W-1:0] rd_data;
  logic [1:0]         res_status;
  logic [SEG_W-1:0]   res_seg;
  logic [OFF_W-1:0]   res_off;

  logic               full, empty, range_bad;
  logic [VALUE_W-1:0] size;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W-1:0] total_next;
  logic               below;
  logic [CNT_W-1:0]   lo_next, hi_next, mid_next, lo_m1;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] prior_sum;
  logic [VALUE_W-1:0] offset_w;
  logic [SNW-1:0]     seg_w;

  assign full      = (count == MAX_CNT);
  assign empty     = (count == '0);
  assign range_bad = (val == '0) || (val > total);

  // Oversized segments saturate, and so does the running total.
  assign size       = (val > SIZE_MAX) ? SIZE_MAX : val;
  assign sum        = {1'b0, total} + {1'b0, size};
  assign total_next = sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];

  // One search step a cycle: the registered read returns the entry at mid_q.
  assign below = (rd_data < val);

  always_comb begin
    if (cmd.start) begin
      lo_next = '0;
      hi_next = count;
    end else if (below) begin
      lo_next = mid_q + CNT_W'(1);
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = mid_q;
    end
  end

  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
  assign lo_m1    = lo_next - CNT_W'(1);
  // When the bounds meet, read the entry before the hit for the offset.
  assign rd_addr  = (lo_next < hi_next) ? mid_next[IDX_W-1:0] : lo_m1[IDX_W-1:0];

  assign prior_sum = (lo == '0) ? '0 : rd_data;
  assign offset_w  = val - prior_sum;
  assign seg_w     = SNW'(lo) + SNW'(1);

  assign stat.search_go = (act == ACT_QUERY) && !empty && !range_bad;
  assign stat.more      = (lo_next < hi_next);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.decode && (act == ACT_APPEND) && !full) begin
      mem[count[IDX_W-1:0]] <= total_next;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.decode) begin
      if (act == ACT_CLEAR) begin
        count <= '0;
        total <= '0;
      end else if ((act == ACT_APPEND) && !full) begin
        count <= count + CNT_W'(1);
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_t'(item_data.action);
      val <= item_data.value;
    end
    if (cmd.start || cmd.step) begin
      lo    <= lo_next;
      hi    <= hi_next;
      mid_q <= mid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_seg <= '0;
      res_off <= '0;
      unique case (act)
        ACT_APPEND: res_status <= full ? ST_FULL : ST_OK;
        ACT_QUERY: begin
          if (empty) begin
            res_status <= ST_EMPTY;
          end else if (range_bad) begin
            res_status <= ST_RANGE;
          end else begin
            res_status <= ST_OK;
          end
        end
        default: res_status <= ST_OK;
      endcase
    end else if (cmd.finish) begin
      res_status <= ST_OK;
      res_seg    <= seg_w[SEG_W-1:0];
      res_off    <= offset_w[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status            <= res_status;
      out_data.segment_number    <= res_seg;
      out_data.offset_in_segment <= res_off;
    end
  end

endmodule

>>> rtl/core/global_index_to_segment_offset.sv
// Segment locator: appends segment sizes into a table of running prefix sums
// and maps a one-based global position to a one-based segment number and
// offset by binary search; each request (clear, append, query) gives one
// result. Requests are handled one at a time. Clear, append, unused codes and
// queries that fail their checks have their result registered in the decode
// state; a query that passes its checks steps through the search state and
// has its result registered in the before state; the search is paced by the
// single read port of the prefix-sum memory, which serves one search step per
// cycle. A new request is accepted while a result still waits in the output
// register; its own result then waits until that register drains. The memory
// needs no clearing after reset. Depends on gis_pkg, gis_stream_if, gis_ctrl
// and gis_datapath.
module global_index_to_segment_offset #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int SIZE_BITS    = 32
) (
  input logic          clk,
  input logic          rst,
  gis_stream_if.sink   item,
  gis_stream_if.source result
);
  import gis_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  in_item_t  item_data;
  out_item_t out_data;

  assign item_data   = item.data;
  assign result.data = out_data;

  gis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  gis_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item_data (item_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

endmodule
